// ===== src/fir89_pkg.sv =====
`default_nettype none
package fir89_pkg;

    localparam int TAPS        = 89;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 17;
    localparam int OUT_BITS    = 40;
    localparam int ROM_LEN     = 89;

    localparam int TAP_W      = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int FILL_W     = $clog2(TAPS + 1);
    localparam int ROM_IDX_W  = $clog2(ROM_LEN);
    localparam int PROD_BITS  = SAMPLE_BITS + COEF_BITS;

    // Q.20 lowpass weights; entry 0 weights the newest sample.
    localparam logic signed [COEF_BITS-1:0] COEF_ROM [ROM_LEN] = '{
         17'sd5732,   17'sd1758,   17'sd1914,   17'sd1992,   17'sd1972,
         17'sd1842,   17'sd1586,   17'sd1196,   17'sd672,    17'sd10,
        -17'sd776,   -17'sd1674,  -17'sd2658,  -17'sd3700,  -17'sd4762,
        -17'sd5802,  -17'sd6768,  -17'sd7612,  -17'sd8278,  -17'sd8712,
        -17'sd8864,  -17'sd8678,  -17'sd8112,  -17'sd7128,  -17'sd5700,
        -17'sd3808,  -17'sd1450,   17'sd1370,   17'sd4626,   17'sd8288,
         17'sd12302,  17'sd16608,  17'sd21132,  17'sd25792,  17'sd30502,
         17'sd35158,  17'sd39660,  17'sd43924,  17'sd47840,  17'sd51326,
         17'sd54296,  17'sd56686,  17'sd58434,  17'sd59500,  17'sd59858,
         17'sd59500,  17'sd58434,  17'sd56686,  17'sd54296,  17'sd51326,
         17'sd47840,  17'sd43924,  17'sd39660,  17'sd35158,  17'sd30502,
         17'sd25792,  17'sd21132,  17'sd16608,  17'sd12302,  17'sd8288,
         17'sd4626,   17'sd1370,  -17'sd1450,  -17'sd3808,  -17'sd5700,
        -17'sd7128,  -17'sd8112,  -17'sd8678,  -17'sd8864,  -17'sd8712,
        -17'sd8278,  -17'sd7612,  -17'sd6768,  -17'sd5802,  -17'sd4762,
        -17'sd3700,  -17'sd2658,  -17'sd1674,  -17'sd776,    17'sd10,
         17'sd672,    17'sd1196,   17'sd1586,   17'sd1842,   17'sd1972,
         17'sd1992,   17'sd1914,   17'sd1758,   17'sd5732
    };

    typedef struct packed {
        logic             start;   // write the new sample, clear the sum
        logic             issue;   // read one tap into the MAC pipe
        logic [TAP_W-1:0] tap;     // tap index, 0 = newest
        logic             finish;  // move the sum to the output register
    } t_dp_cmd;

    typedef struct packed {
        logic busy;      // MAC pipe still holds taps
        logic out_free;  // output register can take a result this cycle
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== src/fir89_ctrl.sv =====
`default_nettype none
module fir89_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire fir89_pkg::t_dp_stat i_stat,
    output fir89_pkg::t_dp_cmd      o_cmd
);
    import fir89_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [TAP_W-1:0] r_tap;
    logic             w_accept;
    logic             w_last_tap;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = (r_state == S_IDLE) && i_in_valid;
    assign w_last_tap = (r_tap == TAP_W'(TAPS - 1));

    always_comb begin
        n_state      = r_state;
        o_cmd.start  = 1'b0;
        o_cmd.issue  = 1'b0;
        o_cmd.tap    = r_tap;
        o_cmd.finish = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
                if (w_last_tap) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // hold until the last product lands and the output slot frees
                if (!i_stat.busy && i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_tap <= '0;
            end else if (r_state == S_RUN && !w_last_tap) begin
                r_tap <= r_tap + 1'b1;
            end
        end
    end

    a_accept_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_RUN) && (r_tap == '0))
        else $error("accepted beat did not start tap walk at tap 0");

    a_run_ends_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) && w_last_tap |=> (r_state == S_DRAIN))
        else $error("tap walk did not move to drain after last tap");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("controller state is not one-hot");

endmodule
`default_nettype wire

// ===== src/fir89_dp.sv =====
`default_nettype none
module fir89_dp (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic signed [fir89_pkg::SAMPLE_BITS-1:0]      i_sample,
    input  wire fir89_pkg::t_dp_cmd                            i_cmd,
    output fir89_pkg::t_dp_stat                                o_stat,
    output logic                                               o_out_valid,
    input  wire logic                                          i_out_stall,
    output logic signed [fir89_pkg::OUT_BITS-1:0]              o_filtered
);
    import fir89_pkg::*;

    // circular sample store, newest at r_ptr
    logic signed [SAMPLE_BITS-1:0] r_mem [TAPS];

    logic [TAP_W-1:0]              r_ptr, n_ptr;
    logic [TAP_W-1:0]              r_addr;
    logic [FILL_W-1:0]             r_fill;

    logic                          r_s1_valid;
    logic                          r_s1_ok;
    logic signed [SAMPLE_BITS-1:0] r_s1_data;
    logic signed [COEF_BITS-1:0]   r_s1_coef;

    logic                          r_s2_valid;
    logic signed [PROD_BITS-1:0]   r_s2_prod;

    logic signed [OUT_BITS-1:0]    r_acc;
    logic                          r_out_valid;
    logic signed [OUT_BITS-1:0]    r_out_data;

    logic signed [SAMPLE_BITS-1:0] w_s1_sample;

    assign n_ptr       = (r_ptr == TAP_W'(TAPS - 1)) ? '0 : r_ptr + 1'b1;
    assign w_s1_sample = r_s1_ok ? r_s1_data : '0;

    assign o_stat.busy     = r_s1_valid || r_s2_valid;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_filtered      = r_out_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mem[n_ptr] <= i_sample;
        end
        r_s1_data <= r_mem[r_addr];
        r_s1_coef <= COEF_ROM[ROM_IDX_W'(i_cmd.tap)];
        r_s2_prod <= PROD_BITS'(r_s1_coef * w_s1_sample);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_addr      <= '0;
            r_fill      <= '0;
            r_s1_valid  <= 1'b0;
            r_s1_ok     <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_ptr  <= n_ptr;
                r_addr <= n_ptr;
                r_acc  <= '0;
                if (r_fill != FILL_W'(TAPS)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end else if (i_cmd.issue) begin
                // walk back toward older samples
                r_addr <= (r_addr == '0) ? TAP_W'(TAPS - 1) : r_addr - 1'b1;
            end
            r_s1_valid <= i_cmd.issue;
            // taps older than anything written since reset count as zero
            r_s1_ok    <= FILL_W'(i_cmd.tap) < r_fill;
            r_s2_valid <= r_s1_valid;
            if (r_s2_valid) begin
                r_acc <= r_acc + OUT_BITS'(r_s2_prod);
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_data <= r_acc;
        end
    end

    a_finish_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> !r_s1_valid && !r_s2_valid)
        else $error("result taken while products still in flight");

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> !r_s1_valid && !r_s2_valid && !i_cmd.issue)
        else $error("new sample started during tap walk");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(TAPS))
        else $error("fill count beyond tap count");

    a_finish_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> !r_out_valid || !i_out_stall)
        else $error("pending result overwritten");

endmodule
`default_nettype wire

// ===== src/fir_lowpass_89_tap.sv =====
`default_nettype none
// 89-tap symmetric lowpass FIR for signed 16-bit signal-strength samples. Each
// input beat shifts one sample into the delay line (newest weighted by the first
// coefficient) and yields one 40-bit output beat: the exact sum in Q.20, i.e.
// value times 2^20. The delay line reads as zeros after reset, so the first 88
// outputs see a short window. One shared multiply-accumulate walks the taps, one
// per cycle, from a single-port sample memory; an item occupies the block through
// the accept, 89 taps and the drain of the read and multiply stages, and the
// next beat is taken after that. A finished result waits in an output register,
// so the next sample is accepted while it is still stalled. No clearing pass
// follows reset; a fill count masks entries not yet written.
module fir_lowpass_89_tap (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_in_valid,
    output logic                                           o_in_stall,
    input  wire logic signed [fir89_pkg::SAMPLE_BITS-1:0]  i_sample,
    output logic                                           o_out_valid,
    input  wire logic                                      i_out_stall,
    output logic signed [fir89_pkg::OUT_BITS-1:0]          o_filtered
);
    import fir89_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    fir89_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    fir89_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (i_sample),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_filtered  (o_filtered)
    );

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import fir89_pkg::*;

    localparam int N_RANDOM = 2000;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_PRINTS = 20;
    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 16'sh8000;

    // Q.20 lowpass weights, index 0 weights the newest sample
    localparam int LP_WEIGHTS [TAPS] = '{
         5732,  1758,  1914,  1992,  1972,  1842,  1586,  1196,   672,    10,
         -776, -1674, -2658, -3700, -4762, -5802, -6768, -7612, -8278, -8712,
        -8864, -8678, -8112, -7128, -5700, -3808, -1450,  1370,  4626,  8288,
        12302, 16608, 21132, 25792, 30502, 35158, 39660, 43924, 47840, 51326,
        54296, 56686, 58434, 59500, 59858, 59500, 58434, 56686, 54296, 51326,
        47840, 43924, 39660, 35158, 30502, 25792, 21132, 16608, 12302,  8288,
         4626,  1370, -1450, -3808, -5700, -7128, -8112, -8678, -8864, -8712,
        -8278, -7612, -6768, -5802, -4762, -3700, -2658, -1674,  -776,    10,
          672,  1196,  1586,  1842,  1972,  1992,  1914,  1758,  5732
    };

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        int unsigned                   gap;    // idle cycles after this beat
        bit                            drain;  // wait for all results before offering
    } beat_t;

    typedef enum {SEG_UNIFORM, SEG_SMALL, SEG_CONST, SEG_IMPULSE, SEG_PEAK, SEG_TOGGLE}
        seg_kind_t;
    typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY} rx_mode_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic signed [SAMPLE_BITS-1:0] in_sample = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [OUT_BITS-1:0]    filtered;

    beat_t                         send_q[$];
    logic signed [OUT_BITS-1:0]    filtered_q[$];
    logic signed [SAMPLE_BITS-1:0] history [TAPS] = '{default: '0};

    int n_queued = 0;
    int n_offered = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_errors = 0;
    int n_drains = 0;
    int n_holds = 0;
    int burst_left = 0;
    bit drain_next = 1'b0;
    bit no_idle = 1'b0;

    fir_lowpass_89_tap DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_sample    (in_sample),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_filtered  (filtered)
    );

    always #4 clk = ~clk;

    // Shift one sample into the delay line and return the exact Q.20 sum.
    function automatic logic signed [OUT_BITS-1:0] shift_and_filter(
        input logic signed [SAMPLE_BITS-1:0] s);
        longint acc;
        acc = 0;
        for (int k = TAPS - 1; k > 0; k--)
            history[k] = history[k - 1];
        history[0] = s;
        for (int k = 0; k < TAPS; k++)
            acc += longint'(LP_WEIGHTS[k]) * longint'(history[k]);
        return acc[OUT_BITS-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        if (n_errors < MAX_PRINTS)
            $display("MISMATCH: %s", msg);
        n_errors++;
    endtask

    task automatic add_beat(input logic signed [SAMPLE_BITS-1:0] s);
        beat_t b;
        b.sample = s;
        b.drain = drain_next;
        b.gap = 0;
        if (drain_next)
            n_drains++;
        drain_next = 1'b0;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            b.gap = no_idle ? 0 : $urandom_range(1, 40);
        end
        burst_left--;
        send_q.push_back(b);
        n_queued++;
    endtask

    // Sender: offer queued beats, hold each until taken.
    always @(negedge clk) begin : drive
        logic  v;
        beat_t b;
        int    gap_left;
        if (rst_n) begin
            v = in_valid;
            if (v && n_accepted == n_offered)
                v = 1'b0;
            if (!v) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (send_q.size() != 0 &&
                             !(send_q[0].drain && filtered_q.size() != 0)) begin
                    b = send_q.pop_front();
                    in_sample <= b.sample;
                    gap_left = b.gap;
                    n_offered++;
                    v = 1'b1;
                end
            end
            in_valid <= v;
        end
    end

    // Receiver: stall pattern in random modes, plus long hold-offs.
    always @(negedge clk) begin : receive
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        if (rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (n_holds < 2 && n_results >= (n_holds == 0 ? 30 : 1200)) begin
                n_holds++;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end else begin
                if (mode_left <= 0) begin
                    mode = rx_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(50, 400);
                end else begin
                    mode_left--;
                end
                case (mode)
                    RX_FREE:  out_stall <= 1'b0;
                    RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    default:  out_stall <= ($urandom_range(0, 9) < 7);
                endcase
            end
        end
    end

    always @(posedge clk) begin : observe
        logic signed [OUT_BITS-1:0] want;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                filtered_q.push_back(shift_and_filter(in_sample));
                n_accepted++;
            end
            if (out_valid && !out_stall) begin
                if (filtered_q.size() == 0) begin
                    report_mismatch($sformatf("output beat %0d with nothing pending: %0d",
                                              n_results, filtered));
                end else begin
                    want = filtered_q.pop_front();
                    if (filtered !== want)
                        report_mismatch($sformatf("beat %0d filtered got %0d, expected %0d",
                                                  n_results, filtered, want));
                end
                n_results++;
            end
        end
    end

    initial begin
        seg_kind_t   kind;
        int          len;
        int          d;
        bit          polarity;
        logic [15:0] lvl;
        int unsigned r;

        // Directed: extremes and short-window start-up
        no_idle = 1'b1;
        add_beat(S_MAX);
        add_beat(S_MIN);
        add_beat(S_MAX);
        add_beat(S_MIN);
        add_beat('0);
        add_beat(16'sd1);
        add_beat(-16'sd1);
        add_beat(16'sh5555);
        add_beat(16'shAAAA);
        add_beat(16'sh00FF);
        add_beat(16'shFF00);
        add_beat(16'sd12345);
        add_beat(-16'sd12345);
        add_beat(S_MAX);
        add_beat(S_MAX);
        add_beat(S_MAX);
        add_beat(S_MIN);
        add_beat(S_MIN);
        add_beat(S_MIN);
        add_beat('0);
        add_beat('0);
        add_beat(16'sd256);

        drain_next = 1'b1;
        while (n_queued < N_RANDOM + 22) begin
            kind = seg_kind_t'($urandom_range(0, 5));
            len = $urandom_range(20, 120);
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 5) == 0)
                drain_next = 1'b1;
            r = $urandom();
            lvl = r[15:0];
            polarity = $urandom_range(0, 1);
            case (kind)
                SEG_UNIFORM:
                    repeat (len) begin
                        r = $urandom();
                        add_beat(r[15:0]);
                    end
                SEG_SMALL:
                    repeat (len) begin
                        d = int'($urandom_range(0, 200)) - 100;
                        add_beat(d[15:0]);
                    end
                SEG_CONST:
                    repeat (len) add_beat(lvl);
                SEG_IMPULSE: begin
                    add_beat(lvl);
                    repeat (len) add_beat('0);
                end
                // align full-scale samples with the weight signs: peak output
                SEG_PEAK:
                    for (int j = 0; j < TAPS + 8; j++)
                        add_beat(((LP_WEIGHTS[TAPS - 1 - (j % TAPS)] >= 0) ^ polarity)
                                 ? S_MAX : S_MIN);
                default:
                    repeat (len) begin
                        add_beat(polarity ? S_MAX : S_MIN);
                        polarity = !polarity;
                    end
            endcase
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (n_accepted == n_queued);
        wait (filtered_q.size() == 0);
        repeat (200) @(posedge clk);
        if (filtered_q.size() != 0)
            report_mismatch($sformatf("%0d filtered beats never arrived", filtered_q.size()));

        $display("Run: %0d samples filtered, %0d output beats checked, %0d mismatches.",
                 n_accepted, n_results, n_errors);
        $display("Stress: %0d long receiver hold-offs, %0d sender drain pauses.",
                 n_holds, n_drains);
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("Timeout: %0d of %0d samples taken, %0d results pending.",
                 n_accepted, n_queued, filtered_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
